// File: rtl/jls_pkg.sv
`default_nettype none
package jls_pkg;
    localparam int MAX_SIZE   = 16;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 24;
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 8;
    localparam int CNT_W      = 5;
    localparam int PROD_W     = 2 * VALUE_BITS;
    localparam int QUO_W      = VALUE_BITS + FRAC_BITS;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

    localparam logic [1:0] CFG_TOL   = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD_A, OP_LOAD_B, OP_RD_DIAG, OP_CHK_DIAG, OP_RD_ELEM,
        OP_DIV_START, OP_DIV_STEP, OP_WR_A, OP_WR_B, OP_INIT_X, OP_COPY_X,
        OP_MAC_RD, OP_MAC, OP_ROW_END, OP_ZERO_X
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic             first;
        logic             off;
    } t_cmd;

    typedef struct packed {
        logic diag_zero;
        logic div_done;
        logic over_tol;
    } t_stat;

    // saturate a signed wide value to VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] sat_w(input logic signed [VALUE_BITS+1:0] v);
        logic signed [VALUE_BITS+1:0] hi;
        logic signed [VALUE_BITS+1:0] lo;
        hi = {{2{1'b0}}, VMAX};
        lo = {{2{1'b1}}, VMIN};
        if (v > hi) return VMAX;
        if (v < lo) return VMIN;
        return v[VALUE_BITS-1:0];
    endfunction

    // magnitude plus sign to saturated two's complement
    function automatic logic [VALUE_BITS-1:0] from_sm(input logic neg,
                                                      input logic [QUO_W-1:0] m);
        logic big;
        logic [VALUE_BITS-1:0] lo;
        big = |m[QUO_W-1:VALUE_BITS];
        lo  = m[VALUE_BITS-1:0];
        if (!neg) return (big || lo > VMAX) ? VMAX : lo;
        if (big || lo > VMIN) return VMIN;
        return VALUE_BITS'(-lo);
    endfunction
endpackage
`default_nettype wire

// File: rtl/jacobi_linear_solver_core.sv
// Jacobi solver core, Q8.24 fixed point, up to 16 unknowns.
// Load requests: one per cycle while idle. Solve: diagonal checks, then per-row
// scaling (56 quotient bits per element, one per cycle from a shared divider),
// then seeding, then sweeps.
// Results: n, one per accepted output cycle; next request after the last one.
// Reset: synchronous, active low; control and config to 17/16/1000, no stores.
`default_nettype none
module jacobi_linear_solver_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_row,
    input  wire logic [3:0]  i_col,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_index,
    output logic [31:0]      o_solution,
    output logic [15:0]      o_iterations,
    output logic [1:0]       o_status,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [30:0] i_cfg_data
);
    logic [30:0] r_tol;
    logic [4:0]  r_size;
    logic [15:0] r_limit;
    jls_pkg::t_cmd  w_cmd;
    jls_pkg::t_stat w_stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 31'd17; r_size <= 5'd16; r_limit <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jls_pkg::CFG_TOL:   r_tol <= i_cfg_data;
                jls_pkg::CFG_SIZE:  r_size <= i_cfg_data[4:0];
                jls_pkg::CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    jls_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_cmd,
        .i_size(r_size), .i_limit(r_limit), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_valid, .i_ready, .o_index, .o_iterations, .o_status, .o_last
    );

    jls_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_row, .i_col, .i_value,
        .i_tol(r_tol), .i_out_idx(o_index), .o_stat(w_stat), .o_x(o_solution)
    );
endmodule
`default_nettype wire

// File: rtl/jls_datapath.sv
`default_nettype none
module jls_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire jls_pkg::t_cmd                   i_cmd,
    input  wire logic [jls_pkg::IDX_W-1:0]       i_row,
    input  wire logic [jls_pkg::IDX_W-1:0]       i_col,
    input  wire logic [jls_pkg::VALUE_BITS-1:0]  i_value,
    input  wire logic [30:0]                     i_tol,
    input  wire logic [jls_pkg::IDX_W-1:0]       i_out_idx,
    output jls_pkg::t_stat                       o_stat,
    output logic [jls_pkg::VALUE_BITS-1:0]       o_x
);
    localparam int VB = jls_pkg::VALUE_BITS;
    localparam int QW = jls_pkg::QUO_W;

    logic [VB-1:0] r_a_mem [0:255];
    logic [VB-1:0] r_b_mem [0:jls_pkg::MAX_SIZE-1];
    logic [VB-1:0] r_xc    [0:jls_pkg::MAX_SIZE-1];
    logic [VB-1:0] r_xn    [0:jls_pkg::MAX_SIZE-1];

    logic [VB-1:0] r_a_rd, r_diag, r_prod, r_sum, r_x_j;
    logic [VB:0]   r_max;
    logic          r_neg;
    logic [QW-1:0] r_quo;
    logic [VB-1:0] r_rem;
    logic [VB-1:0] r_den;
    logic [6:0]    r_dcnt;
    logic          r_diag_zero;

    logic [jls_pkg::ADDR_W-1:0] w_addr;
    logic [VB-1:0]              w_mag_a, w_mag_x, w_wr_val;
    logic [jls_pkg::PROD_W-1:0] w_p;
    logic [VB:0]                w_rtry;
    logic                       w_bit;
    logic signed [VB+1:0]       w_s, w_xs;
    logic [VB-1:0]              w_new;
    logic [VB:0]                w_chg;

    assign w_addr   = {i_cmd.i, i_cmd.j};
    assign w_mag_a  = r_a_rd[VB-1] ? VB'(-r_a_rd) : r_a_rd;
    assign w_mag_x  = r_x_j[VB-1] ? VB'(-r_x_j) : r_x_j;
    assign w_p      = w_mag_a * w_mag_x;
    assign w_rtry   = {r_rem, w_bit} - {1'b0, r_den};
    assign w_bit    = r_quo[QW-1];
    assign w_wr_val = jls_pkg::from_sm(r_neg, r_quo);

    assign w_s   = $signed({{2{r_sum[VB-1]}}, r_sum}) + $signed({{2{r_prod[VB-1]}}, r_prod});
    assign w_xs  = $signed({{2{r_b_mem[i_cmd.i][VB-1]}}, r_b_mem[i_cmd.i]})
                   + $signed({{2{r_sum[VB-1]}}, r_sum});
    assign w_new = jls_pkg::sat_w(w_xs);
    always_comb begin
        logic signed [VB+1:0] d;
        d = $signed({{2{r_xc[i_cmd.i][VB-1]}}, r_xc[i_cmd.i]})
            - $signed({{2{w_new[VB-1]}}, w_new});
        w_chg = d[VB+1] ? (VB+1)'(-d) : d[VB:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            jls_pkg::OP_LOAD_A: r_a_mem[{i_row, i_col}] <= i_value;
            jls_pkg::OP_LOAD_B: r_b_mem[i_row] <= i_value;
            jls_pkg::OP_RD_DIAG, jls_pkg::OP_RD_ELEM, jls_pkg::OP_MAC_RD:
                r_a_rd <= r_a_mem[w_addr];
            // the diagonal entry of a scaled row becomes zero
            jls_pkg::OP_WR_A: r_a_mem[w_addr] <= (i_cmd.i == i_cmd.j) ? '0 : w_wr_val;
            jls_pkg::OP_WR_B: r_b_mem[i_cmd.i] <= w_wr_val;
            jls_pkg::OP_ZERO_X: r_xn[i_cmd.i] <= '0;
            jls_pkg::OP_INIT_X: r_xn[i_cmd.i] <= r_b_mem[i_cmd.i];
            jls_pkg::OP_COPY_X: r_xc[i_cmd.i] <= r_xn[i_cmd.i];
            jls_pkg::OP_ROW_END: r_xn[i_cmd.i] <= w_new;
            default: ;
        endcase
        if (i_cmd.op == jls_pkg::OP_CHK_DIAG) r_diag <= r_a_rd;
        if (i_cmd.op == jls_pkg::OP_RD_ELEM || i_cmd.op == jls_pkg::OP_MAC_RD)
            r_x_j <= r_xc[i_cmd.j];
        if (i_cmd.op == jls_pkg::OP_MAC) begin
            r_prod <= jls_pkg::from_sm(r_a_rd[VB-1] ^ r_x_j[VB-1],
                                       QW'(w_p >> jls_pkg::FRAC_BITS));
        end
        if (i_cmd.op == jls_pkg::OP_MAC_RD && i_cmd.first) begin
            r_sum  <= '0;
            r_prod <= '0;
        end else if (i_cmd.op == jls_pkg::OP_MAC_RD) begin
            r_sum <= jls_pkg::sat_w(w_s);
        end
        if (i_cmd.op == jls_pkg::OP_ROW_END) begin
            if (i_cmd.first || w_chg > r_max) r_max <= w_chg;
        end
        if (i_cmd.op == jls_pkg::OP_DIV_STEP) begin
            r_quo  <= {r_quo[QW-2:0], ~w_rtry[VB]};
            r_rem  <= w_rtry[VB] ? {r_rem[VB-2:0], w_bit} : w_rtry[VB-1:0];
            r_dcnt <= r_dcnt + 7'd1;
        end else if (i_cmd.op == jls_pkg::OP_RD_ELEM) begin
            r_dcnt <= '0;
        end else if (i_cmd.op == jls_pkg::OP_DIV_START) begin
            r_dcnt <= '0;
        end
        if (i_cmd.op == jls_pkg::OP_DIV_START) begin
            r_den <= r_diag[VB-1] ? VB'(-r_diag) : r_diag;
            r_neg <= (i_cmd.off ? r_b_mem[i_cmd.i][VB-1] : r_a_rd[VB-1])
                     ^ r_diag[VB-1] ^ ~i_cmd.off;
            r_quo <= {(i_cmd.off ? (r_b_mem[i_cmd.i][VB-1] ? VB'(-r_b_mem[i_cmd.i])
                                                           : r_b_mem[i_cmd.i])
                                 : (r_a_rd[VB-1] ? VB'(-r_a_rd) : r_a_rd)),
                      {jls_pkg::FRAC_BITS{1'b0}}};
            r_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diag_zero <= 1'b0;
        end else if (i_cmd.op == jls_pkg::OP_CHK_DIAG) begin
            r_diag_zero <= (i_cmd.first ? 1'b0 : r_diag_zero) | (r_a_rd == '0);
        end
    end

    assign o_stat.diag_zero = r_diag_zero;
    assign o_stat.div_done  = (r_dcnt == 7'(QW - 1)) && (i_cmd.op == jls_pkg::OP_DIV_STEP);
    assign o_stat.over_tol  = r_max > {2'b0, i_tol};
    assign o_x              = r_xn[i_out_idx];
endmodule
`default_nettype wire

// File: rtl/jls_ctrl.sv
`default_nettype none
module jls_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_cmd,
    input  wire logic [4:0]                 i_size,
    input  wire logic [15:0]                i_limit,
    input  wire jls_pkg::t_stat             i_stat,
    output jls_pkg::t_cmd                   o_cmd,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [jls_pkg::IDX_W-1:0]       o_index,
    output logic [15:0]                     o_iterations,
    output logic [1:0]                      o_status,
    output logic                            o_last
);
    localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DCHK = 4'd2, S_DDEC = 4'd3,
        S_SRD = 4'd4, S_SLD = 4'd5, S_SDIV = 4'd6, S_SWR = 4'd7, S_INIT = 4'd8,
        S_COPY = 4'd9, S_MRD = 4'd10, S_MAC = 4'd11, S_REND = 4'd12, S_CHK = 4'd13,
        S_OUT = 4'd14, S_ZERO = 4'd15;

    logic [3:0]  r_state, n_state;
    logic [jls_pkg::IDX_W-1:0] r_i, n_i, r_j, n_j, w_nm1;
    logic        r_off, n_off, r_wait, n_wait;
    logic [15:0] r_sweeps, n_sweeps;
    logic [1:0]  r_status, n_status;
    logic [15:0] w_lim;
    logic        w_acc;

    assign w_nm1 = (i_size == 5'd0) ? '0 : (i_size > 5'd16) ? 4'd15 : 4'(i_size - 5'd1);
    assign w_lim = (i_limit == 16'd0) ? 16'd1 : i_limit;
    assign o_ready = (r_state == S_IDLE);
    assign w_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_i <= '0; r_j <= '0; r_off <= 1'b0; r_wait <= 1'b0;
            r_sweeps <= '0; r_status <= jls_pkg::ST_CONVERGED;
        end else begin
            r_state <= n_state; r_i <= n_i; r_j <= n_j; r_off <= n_off; r_wait <= n_wait;
            r_sweeps <= n_sweeps; r_status <= n_status;
        end
    end

    always_comb begin
        n_state = r_state; n_i = r_i; n_j = r_j; n_off = r_off; n_wait = r_wait;
        n_sweeps = r_sweeps; n_status = r_status;
        o_cmd = '{op: jls_pkg::OP_NONE, i: r_i, j: r_j, first: 1'b0, off: r_off};
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_cmd)
                        jls_pkg::CMD_LOAD_A: o_cmd.op = jls_pkg::OP_LOAD_A;
                        jls_pkg::CMD_LOAD_B: o_cmd.op = jls_pkg::OP_LOAD_B;
                        jls_pkg::CMD_START: begin
                            n_state = S_DRD; n_i = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_DRD: begin
                o_cmd.op = jls_pkg::OP_RD_DIAG; o_cmd.j = r_i; n_state = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.op = jls_pkg::OP_CHK_DIAG; o_cmd.first = (r_i == '0);
                if (r_i == w_nm1) n_state = S_DDEC;
                else begin n_i = r_i + 1'b1; n_state = S_DRD; end
            end
            S_DDEC: begin
                n_i = '0;
                if (i_stat.diag_zero) begin
                    n_state = S_ZERO; n_status = jls_pkg::ST_ZERO_DIAG; n_sweeps = '0;
                end else begin
                    n_state = S_SRD; n_j = '0; n_off = 1'b0;
                end
            end
            S_ZERO: begin
                o_cmd.op = jls_pkg::OP_ZERO_X;
                if (r_i == w_nm1) begin n_state = S_OUT; n_i = '0; end
                else n_i = r_i + 1'b1;
            end
            // row scaling: diagonal reread into divisor register each row
            S_SRD: begin
                o_cmd.op = jls_pkg::OP_RD_DIAG; o_cmd.j = r_i; n_state = S_SLD; n_wait = 1'b1;
            end
            S_SLD: begin
                if (r_wait) begin
                    o_cmd.op = jls_pkg::OP_CHK_DIAG; o_cmd.first = 1'b1; n_wait = 1'b0;
                end else if (!r_off && r_j == r_i) begin
                    o_cmd.op = jls_pkg::OP_NONE; n_state = S_SWR;
                end else begin
                    o_cmd.op = jls_pkg::OP_RD_ELEM; n_state = S_SDIV; n_wait = 1'b1;
                end
            end
            S_SDIV: begin
                if (r_wait) begin
                    o_cmd.op = jls_pkg::OP_DIV_START; n_wait = 1'b0;
                end else begin
                    o_cmd.op = jls_pkg::OP_DIV_STEP;
                    if (i_stat.div_done) n_state = S_SWR;
                end
            end
            S_SWR: begin
                o_cmd.op = r_off ? jls_pkg::OP_WR_B : jls_pkg::OP_WR_A;
                n_state = S_SLD;
                if (r_off) begin
                    n_off = 1'b0; n_j = '0;
                    if (r_i == w_nm1) begin n_state = S_INIT; n_i = '0; end
                    else begin n_i = r_i + 1'b1; n_state = S_SRD; end
                end else if (r_j == w_nm1) n_off = 1'b1;
                else n_j = r_j + 1'b1;
            end
            S_INIT: begin
                o_cmd.op = jls_pkg::OP_INIT_X;
                if (r_i == w_nm1) begin n_state = S_COPY; n_i = '0; n_sweeps = '0; end
                else n_i = r_i + 1'b1;
            end
            S_COPY: begin
                o_cmd.op = jls_pkg::OP_COPY_X;
                if (r_i == w_nm1) begin n_state = S_MRD; n_i = '0; n_j = '0; end
                else n_i = r_i + 1'b1;
            end
            S_MRD: begin
                o_cmd.op = jls_pkg::OP_MAC_RD; o_cmd.first = (r_j == '0); n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.op = jls_pkg::OP_MAC;
                if (r_j == w_nm1) n_state = S_REND;
                else begin n_j = r_j + 1'b1; n_state = S_MRD; end
            end
            S_REND: begin
                // fold last product, then add offset
                o_cmd.op = r_wait ? jls_pkg::OP_ROW_END : jls_pkg::OP_MAC_RD;
                o_cmd.first = r_wait ? (r_i == '0) : 1'b0;
                o_cmd.j = r_j;
                n_wait = ~r_wait;
                if (r_wait) begin
                    n_j = '0;
                    if (r_i == w_nm1) begin n_state = S_CHK; n_sweeps = r_sweeps + 16'd1; end
                    else begin n_i = r_i + 1'b1; n_state = S_MRD; end
                end
            end
            S_CHK: begin
                n_i = '0;
                if (i_stat.over_tol && r_sweeps < w_lim) n_state = S_COPY;
                else begin
                    n_state = S_OUT;
                    n_status = i_stat.over_tol ? jls_pkg::ST_LIMIT : jls_pkg::ST_CONVERGED;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    if (r_i == w_nm1) n_state = S_IDLE;
                    else n_i = r_i + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid      = (r_state == S_OUT);
    assign o_index      = r_i;
    assign o_iterations = r_sweeps;
    assign o_status     = r_status;
    assign o_last       = (r_i == w_nm1);
endmodule
`default_nettype wire
